[src/spc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_pkg: shared types and constants of the stack permutation checker
// Car field widths, action codes, sequencer states and the stack memory
// access bundle.
// ----------------------------------------------------------------------------
package spc_pkg;

   localparam int CAR_W        = 6;
   localparam int ADDR_W       = 6;
   localparam int MAX_CARS_DEF = 32;

   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_POP  = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_POP   = 3'b010,
      S_FETCH = 3'b100
   } seq_state_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [CAR_W-1:0]  wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

endpackage

[src/spc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_req_if / spc_rsp_if: request and result channels
// Valid/ready channels that carry an arriving car and one push or pop result.
// ----------------------------------------------------------------------------
interface spc_req_if;
   logic                        valid;
   logic                        ready;
   logic [spc_pkg::CAR_W-1:0]   car_number;
   logic                        last_car;

   modport source (output valid, output car_number, output last_car, input ready);
   modport sink   (input valid, input car_number, input last_car, output ready);
endinterface

interface spc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        action;
   logic [spc_pkg::CAR_W-1:0]   car_moved;
   logic                        end_of_run;
   logic                        sequence_done;
   logic                        possible;

   modport source (output valid, output action, output car_moved, output end_of_run,
                   output sequence_done, output possible, input ready);
   modport sink   (input valid, input action, input car_moved, input end_of_run,
                   input sequence_done, input possible, output ready);
endinterface

[src/spc_stack_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_stack_mem: car stack storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module spc_stack_mem #(
   parameter int MAX_CARS = spc_pkg::MAX_CARS_DEF
) (
   input  logic                       clock,
   input  spc_pkg::mem_req_type       mem_req,
   output logic [spc_pkg::CAR_W-1:0]  mem_rdata
);

   localparam int AW = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;

   logic [spc_pkg::CAR_W-1:0] stack_mem [MAX_CARS];
   logic [spc_pkg::CAR_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         stack_mem[mem_req.waddr[AW-1:0]] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rdata_ff <= stack_mem[mem_req.raddr[AW-1:0]];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

[src/spc_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_seq: push/pop sequencer
// Pushes each request unless full, pops while the cached top matches the
// expected car, refills the top from memory after each pop, registers results.
// ----------------------------------------------------------------------------
module spc_seq #(
   parameter int MAX_CARS = spc_pkg::MAX_CARS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   spc_req_if.sink                    req_bus,
   spc_rsp_if.source                  rsp_bus,
   output spc_pkg::mem_req_type       mem_req,
   input  logic [spc_pkg::CAR_W-1:0]  mem_rdata
);

   localparam int CNT_W = $clog2(MAX_CARS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CARS);
   localparam logic [spc_pkg::CAR_W-1:0] EXP_INIT = spc_pkg::CAR_W'(1);

   spc_pkg::seq_state_type state_ff, state_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [spc_pkg::CAR_W-1:0] exp_ff, exp_in;
   logic                      ovf_ff, ovf_in;
   logic [spc_pkg::CAR_W-1:0] top_ff, top_in;
   logic [spc_pkg::CAR_W-1:0] pend_ff, pend_in;
   logic                      last_ff, last_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      act_ff, act_in;
   logic [spc_pkg::CAR_W-1:0] car_ff, car_in;
   logic                      eor_ff, eor_in;
   logic                      done_ff, done_in;
   logic                      poss_ff, poss_in;

   logic                      slot_free;
   logic                      accept;
   logic                      full;
   logic [CNT_W-1:0]          push_cnt;
   logic [spc_pkg::CAR_W-1:0] push_top;
   logic                      push_ovf;
   logic                      push_pop;
   logic                      fetch_pop;
   logic                      load;
   logic                      seq_end;

   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == spc_pkg::S_IDLE) && slot_free;
   assign accept        = req_bus.valid && req_bus.ready;

   assign full      = (cnt_ff == CNT_MAX);
   assign push_cnt  = full ? cnt_ff : cnt_ff + CNT_W'(1);
   assign push_top  = full ? top_ff : req_bus.car_number;
   assign push_ovf  = ovf_ff | full;
   assign push_pop  = (push_cnt != '0) && (push_top == exp_ff);
   assign fetch_pop = (cnt_ff != '0) && (mem_rdata == exp_ff);

   always_comb begin
      mem_req.we    = accept && !full;
      mem_req.waddr = spc_pkg::ADDR_W'(cnt_ff);
      mem_req.wdata = req_bus.car_number;
      mem_req.re    = (state_ff == spc_pkg::S_POP) && slot_free && (cnt_ff >= CNT_W'(2));
      mem_req.raddr = spc_pkg::ADDR_W'(cnt_ff - CNT_W'(2));
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      exp_in   = exp_ff;
      ovf_in   = ovf_ff;
      top_in   = top_ff;
      pend_in  = pend_ff;
      last_in  = last_ff;
      act_in   = act_ff;
      car_in   = car_ff;
      eor_in   = eor_ff;
      done_in  = done_ff;
      poss_in  = poss_ff;
      load     = 1'b0;
      seq_end  = 1'b0;

      unique case (state_ff)
         spc_pkg::S_IDLE: begin
            if (accept) begin
               load     = 1'b1;
               cnt_in   = push_cnt;
               top_in   = push_top;
               ovf_in   = push_ovf;
               last_in  = req_bus.last_car;
               act_in   = spc_pkg::ACT_PUSH;
               car_in   = req_bus.car_number;
               eor_in   = !push_pop;
               done_in  = req_bus.last_car && !push_pop;
               poss_in  = req_bus.last_car && !push_pop && (push_cnt == '0) && !push_ovf;
               seq_end  = req_bus.last_car && !push_pop;
               state_in = push_pop ? spc_pkg::S_POP : spc_pkg::S_IDLE;
            end
         end
         spc_pkg::S_POP: begin
            // pop the cached top and fetch the entry below it
            if (slot_free) begin
               pend_in  = top_ff;
               cnt_in   = cnt_ff - CNT_W'(1);
               exp_in   = exp_ff + spc_pkg::CAR_W'(1);
               state_in = spc_pkg::S_FETCH;
            end
         end
         spc_pkg::S_FETCH: begin
            load     = 1'b1;
            top_in   = mem_rdata;
            act_in   = spc_pkg::ACT_POP;
            car_in   = pend_ff;
            eor_in   = !fetch_pop;
            done_in  = last_ff && !fetch_pop;
            poss_in  = last_ff && !fetch_pop && (cnt_ff == '0) && !ovf_ff;
            seq_end  = last_ff && !fetch_pop;
            state_in = fetch_pop ? spc_pkg::S_POP : spc_pkg::S_IDLE;
         end
         default: begin
            state_in = spc_pkg::S_IDLE;
         end
      endcase

      // clear the stack count, expected car and overflow flag with the final result
      if (seq_end) begin
         cnt_in = '0;
         exp_in = EXP_INIT;
         ovf_in = 1'b0;
      end
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spc_pkg::S_IDLE;
         cnt_ff       <= '0;
         exp_ff       <= EXP_INIT;
         ovf_ff       <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         exp_ff       <= exp_in;
         ovf_ff       <= ovf_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff  <= top_in;
      pend_ff <= pend_in;
      act_ff  <= act_in;
      car_ff  <= car_in;
      eor_ff  <= eor_in;
      done_ff <= done_in;
      poss_ff <= poss_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.action        = act_ff;
   assign rsp_bus.car_moved     = car_ff;
   assign rsp_bus.end_of_run    = eor_ff;
   assign rsp_bus.sequence_done = done_ff;
   assign rsp_bus.possible      = poss_ff;

endmodule

[src/stack_permutation_checker.sv]
`timescale 1ns / 1ps
// Push result is registered at the edge that takes the request. Each pop
//   passes a pop state, which waits for the result slot, then a fetch state
//   whose memory read refills the cached top; no car is taken meanwhile.
// Reset: synchronous; clears stack count, overflow flag and valid, sets the
//   expected car to one. Stack memory contents are not cleared.
// ----------------------------------------------------------------------------
// stack_permutation_checker: stack sequence validation
// Pushes arriving cars through one stack and pops them in ascending order,
// reporting each move and whether the sequence could be fully reordered.
// ----------------------------------------------------------------------------
module stack_permutation_checker #(
   parameter int MAX_CARS = spc_pkg::MAX_CARS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   spc_req_if.sink    req_bus,
   spc_rsp_if.source  rsp_bus
);

   spc_pkg::mem_req_type       mem_req;
   logic [spc_pkg::CAR_W-1:0]  mem_rdata;

   spc_seq #(
      .MAX_CARS (MAX_CARS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   spc_stack_mem #(
      .MAX_CARS (MAX_CARS)
   ) u_stack_mem (
      .clock     (clock),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stack permutation checker verification
// Sends car sequences through the request channel and checks every push and
// pop result against an in-bench stack predictor. Directed runs cover in-order,
// reversed, impossible, out-of-range, stack-full and counter-wrap sequences;
// random runs mix sortable sequences, corrupted sequences and noise, with
// random idle bursts on both channels.
// ----------------------------------------------------------------------------
module testbench;

   localparam int MAX_CARS    = spc_pkg::MAX_CARS_DEF;
   localparam int RANDOM_CARS = 280;
   localparam int CYCLE_LIMIT = 1500000;

   typedef struct packed {
      logic                      action;
      logic [spc_pkg::CAR_W-1:0] car_moved;
      logic                      end_of_run;
      logic                      sequence_done;
      logic                      possible;
   } car_move_type;

   logic clock;
   logic reset;

   spc_req_if req_bus ();
   spc_rsp_if rsp_bus ();

   stack_permutation_checker #(.MAX_CARS(MAX_CARS)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // predictor state
   logic [spc_pkg::CAR_W-1:0] shadow_stack [MAX_CARS];
   int                        shadow_depth = 0;
   logic [spc_pkg::CAR_W-1:0] shadow_next  = spc_pkg::CAR_W'(1);
   bit                        shadow_overflow = 0;

   car_move_type expected_moves [$];
   int           error_count = 0;
   int           cars_sent   = 0;
   int           cycle_count = 0;
   int           ready_hold  = 0;
   bit           idle_on     = 1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   // Work out the moves one accepted car causes and queue them.
   task automatic predict_moves(input logic [spc_pkg::CAR_W-1:0] car, input bit is_last);
      car_move_type held;
      if (shadow_depth < MAX_CARS) begin
         shadow_stack[shadow_depth] = car;
         shadow_depth++;
      end else begin
         shadow_overflow = 1'b1;
      end
      held = '{spc_pkg::ACT_PUSH, car, 1'b0, 1'b0, 1'b0};
      while (shadow_depth > 0 && shadow_stack[shadow_depth-1] == shadow_next) begin
         expected_moves.insert(expected_moves.size(), held);
         shadow_depth--;
         held = '{spc_pkg::ACT_POP, shadow_stack[shadow_depth], 1'b0, 1'b0, 1'b0};
         shadow_next = shadow_next + 1'b1;
      end
      held.end_of_run = 1'b1;
      if (is_last) begin
         held.sequence_done = 1'b1;
         held.possible = (shadow_depth == 0) && !shadow_overflow;
         shadow_depth = 0;
         shadow_next = spc_pkg::CAR_W'(1);
         shadow_overflow = 1'b0;
      end
      expected_moves.insert(expected_moves.size(), held);
   endtask

   task automatic send_car(input logic [spc_pkg::CAR_W-1:0] car, input bit is_last);
      req_bus.valid      <= 1'b1;
      req_bus.car_number <= car;
      req_bus.last_car   <= is_last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_moves(car, is_last);
      cars_sent++;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic send_sequence(input int cars [$]);
      foreach (cars[i]) send_car(spc_pkg::CAR_W'(cars[i]), i == cars.size() - 1);
   endtask

   // Hold off the sender until every predicted move has come back.
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_moves.size() != 0) @(posedge clock);
   endtask

   // Pass 1..n through a random stack walk, then invert the output order:
   // the result is an arrival order that one stack can sort.
   task automatic build_sortable(input int n, output int cars [$]);
      int popped [$];
      int held [$];
      int next_car;
      next_car = 1;
      cars = {};
      while (popped.size() < n) begin
         if (next_car <= n && (held.size() == 0 || $urandom_range(0, 1) == 1)) begin
            held.insert(held.size(), next_car);
            next_car++;
         end else begin
            popped.insert(popped.size(), held.pop_back());
         end
      end
      repeat (n) cars.insert(cars.size(), 0);
      foreach (popped[i]) cars[popped[i] - 1] = i + 1;
   endtask

   task automatic test_basic_orders();
      send_sequence('{1, 2, 3});
      send_sequence('{3, 2, 1});
      send_sequence('{2, 3, 1});
      send_sequence('{1});
      send_sequence('{5});
   endtask

   // Reversed full stack: the final car releases every stored car.
   task automatic test_max_pops();
      int cars [$];
      for (int c = MAX_CARS; c >= 1; c--) cars.insert(cars.size(), c);
      send_sequence(cars);
   endtask

   task automatic test_car_range();
      send_sequence('{0, 63, 32, 1});
      send_sequence('{2, 1, 63});
   endtask

   // Fill the stack with a car that never pops, then one more overflows it.
   task automatic test_stack_full();
      int cars [$];
      repeat (MAX_CARS) cars.insert(cars.size(), 40);
      cars.insert(cars.size(), 1);
      send_sequence(cars);
   endtask

   // Run the expected counter past 63 so it wraps to zero.
   task automatic test_counter_wrap();
      int cars [$];
      for (int c = 1; c <= 63; c++) cars.insert(cars.size(), c);
      cars.insert(cars.size(), 0);
      cars.insert(cars.size(), 1);
      send_sequence(cars);
   endtask

   task automatic test_random_sequences(input int target);
      int cars [$];
      int first_sent;
      int kind;
      int n;
      bit drained;
      first_sent = cars_sent;
      drained = 1'b0;
      while (cars_sent < first_sent + target) begin
         if (cars_sent >= first_sent + target - 60) idle_on = 1'b0;
         if (!drained && cars_sent >= first_sent + target / 2) begin
            wait_for_drain();
            drained = 1'b1;
         end
         kind = $urandom_range(0, 99);
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, MAX_CARS + 2)
                                         : $urandom_range(1, 8);
         if (kind < 70) begin
            build_sortable(n, cars);
            send_sequence(cars);
         end else if (kind < 85) begin
            build_sortable(n, cars);
            if ($urandom_range(0, 1) == 1)
               cars[$urandom_range(0, n - 1)] = $urandom_range(0, 63);
            else
               while (cars.size() > 1 && $urandom_range(0, 1) == 1) void'(cars.pop_back());
            send_sequence(cars);
         end else begin
            repeat (n) send_car(spc_pkg::CAR_W'($urandom_range(0, 63)),
                                $urandom_range(0, 7) == 0);
         end
      end
   endtask

   // Result checker and receiver backpressure.
   always @(posedge clock) begin
      car_move_type exp_move;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_moves.size() == 0) begin
            $error("unexpected result: action %0d car_moved %0d",
                   rsp_bus.action, rsp_bus.car_moved);
            error_count++;
         end else begin
            exp_move = expected_moves.pop_front();
            if (rsp_bus.action !== exp_move.action) begin
               $error("action expected %0d actual %0d", exp_move.action, rsp_bus.action);
               error_count++;
            end
            if (rsp_bus.car_moved !== exp_move.car_moved) begin
               $error("car_moved expected %0d actual %0d",
                      exp_move.car_moved, rsp_bus.car_moved);
               error_count++;
            end
            if (rsp_bus.end_of_run !== exp_move.end_of_run) begin
               $error("end_of_run expected %0d actual %0d",
                      exp_move.end_of_run, rsp_bus.end_of_run);
               error_count++;
            end
            if (rsp_bus.sequence_done !== exp_move.sequence_done) begin
               $error("sequence_done expected %0d actual %0d",
                      exp_move.sequence_done, rsp_bus.sequence_done);
               error_count++;
            end
            if (rsp_bus.possible !== exp_move.possible) begin
               $error("possible expected %0d actual %0d", exp_move.possible, rsp_bus.possible);
               error_count++;
            end
         end
      end
      if (ready_hold > 0) begin
         ready_hold--;
         rsp_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         ready_hold = $urandom_range(1, 12) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.car_number <= '0;
      req_bus.last_car   <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_basic_orders();
      test_max_pops();
      test_car_range();
      test_stack_full();
      test_counter_wrap();
      test_random_sequences(RANDOM_CARS);

      wait_for_drain();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
